FILE: hdl/lshs_pkg.sv
// Shared types and constants for the light sensor hysteresis / glow slew block.
// No dependencies; imported by every module of the block.
`default_nettype none

package lshs_pkg;

    localparam int TIME_W        = 16;
    localparam int LEVEL_W       = 16;
    localparam int GLOW_W        = 16;
    localparam int ACCUM_W       = 17;
    localparam int SAMPLE_FIELDS = 6;
    localparam int NUM_SAMPLES   = 6;
    localparam int EVENT_W       = 2;

    localparam int IN_W  = TIME_W + SAMPLE_FIELDS * LEVEL_W;
    localparam int OUT_W = ((1 + EVENT_W + LEVEL_W + GLOW_W + 7) / 8) * 8;

    localparam int CFG_AW = 2;
    localparam int CFG_DW = 16;

    localparam logic [CFG_AW-1:0] REG_ON_LIMIT  = 2'd0;
    localparam logic [CFG_AW-1:0] REG_OFF_LIMIT = 2'd1;
    localparam logic [CFG_AW-1:0] REG_INTERVAL  = 2'd2;

    localparam logic [CFG_DW-1:0] INTERVAL_RESET = 16'd2185;

    localparam logic [EVENT_W-1:0] EV_NONE = 2'd0;
    localparam logic [EVENT_W-1:0] EV_ON   = 2'd1;
    localparam logic [EVENT_W-1:0] EV_OFF  = 2'd2;

    localparam logic [GLOW_W-1:0]  FULL_GLOW = {GLOW_W{1'b1}};
    localparam logic [ACCUM_W-1:0] ACCUM_MAX = {ACCUM_W{1'b1}};

    // one quotient bit per divide step
    localparam int DIV_STEPS = GLOW_W;
    localparam int DIV_CNT_W = $clog2(DIV_STEPS);

    typedef struct packed {
        logic cap_in;    // latch the input beat
        logic eval;      // accumulator, level hold, hysteresis
        logic prep;      // signed differences and magnitudes
        logic load;      // goal special cases, dividend set-up
        logic div_step;  // one restoring divide step
        logic slew;      // move glow toward the goal
        logic load_out;  // fill the output register
    } t_dp_cmd;

    typedef struct packed {
        logic use_div;   // goal needs the serial divide
    } t_dp_stat;

endpackage

`default_nettype wire

FILE: hdl/light_sensor_hysteresis_slew.sv
// Light sensor with on/off hysteresis and slew-limited glow.
// States per beat: EVAL, PREP, LOAD, SLEW, DONE when the goal is a limit or a step,
// plus the 16-step serial divide after LOAD when needed; one beat in flight at a time.
// DONE waits until the output register is free before the result is loaded.
// The next input beat is taken while a result waits in the output register.
// Reset (i_rst_n, synchronous, active low): unlit, level and glow zero, limits zero,
// interval 2185.
`default_nettype none

module light_sensor_hysteresis_slew
    import lshs_pkg::*;
(
    input  wire               i_clk,
    input  wire               i_rst_n,
    input  wire               s_axis_tvalid,
    output logic              s_axis_tready,
    // time_step[15:0], light_sample_0[31:16] .. light_sample_5[111:96]
    input  wire  [IN_W-1:0]   s_axis_tdata,
    output logic              m_axis_tvalid,
    input  wire               m_axis_tready,
    // is_lit[0], change_event[2:1], held_level[18:3], glow_amount[34:19], zero pad
    output logic [OUT_W-1:0]  m_axis_tdata,
    input  wire               i_cfg_we,
    input  wire  [CFG_AW-1:0] i_cfg_addr,
    input  wire  [CFG_DW-1:0] i_cfg_data
);

    t_dp_cmd  cmd;
    t_dp_stat stat;

    lshs_ctrl u_ctrl (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .i_stat        (stat),
        .o_cmd         (cmd)
    );

    lshs_dpath u_dpath (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (cmd),
        .o_stat     (stat),
        .i_in_data  (s_axis_tdata),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_addr (i_cfg_addr),
        .i_cfg_data (i_cfg_data),
        .o_out_data (m_axis_tdata)
    );

    // one beat in flight: an accepted beat closes the input until it is done
    a_one_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
        else $error("input accepted while a beat is in flight");

    // the unused event code never appears
    a_event_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (m_axis_tdata[2:1] != 2'b11))
        else $error("invalid change_event code");

    // a turned-on event leaves the cell lit, a turned-off one leaves it unlit
    a_event_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> ((m_axis_tdata[2:1] != EV_ON) || m_axis_tdata[0])
                       && ((m_axis_tdata[2:1] != EV_OFF) || !m_axis_tdata[0]))
        else $error("change_event disagrees with is_lit");

endmodule

`default_nettype wire

FILE: hdl/lshs_ctrl.sv
// Controller FSM for the light sensor block: sequences evaluate, divide and slew.
// Depends on lshs_pkg; drives lshs_dpath through t_dp_cmd.
`default_nettype none

module lshs_ctrl
    import lshs_pkg::*;
(
    input  wire      i_clk,
    input  wire      i_rst_n,
    input  wire      s_axis_tvalid,
    output logic     s_axis_tready,
    output logic     m_axis_tvalid,
    input  wire      m_axis_tready,
    input  t_dp_stat i_stat,
    output t_dp_cmd  o_cmd
);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_EVAL = 3'd1;
    localparam logic [2:0] S_PREP = 3'd2;
    localparam logic [2:0] S_LOAD = 3'd3;
    localparam logic [2:0] S_DIV  = 3'd4;
    localparam logic [2:0] S_SLEW = 3'd5;
    localparam logic [2:0] S_DONE = 3'd6;

    logic [2:0]           r_state, n_state;
    logic [DIV_CNT_W-1:0] r_cnt, n_cnt;
    logic                 r_out_valid, n_out_valid;

    always_comb begin
        n_state     = r_state;
        n_cnt       = r_cnt;
        o_cmd       = '0;
        n_out_valid = r_out_valid;
        if (r_out_valid && m_axis_tready) begin
            n_out_valid = 1'b0;
        end
        case (r_state)
            S_IDLE: begin
                if (s_axis_tvalid) begin
                    o_cmd.cap_in = 1'b1;
                    n_state      = S_EVAL;
                end
            end
            S_EVAL: begin
                o_cmd.eval = 1'b1;
                n_state    = S_PREP;
            end
            S_PREP: begin
                o_cmd.prep = 1'b1;
                n_state    = S_LOAD;
            end
            S_LOAD: begin
                o_cmd.load = 1'b1;
                n_cnt      = '0;
                n_state    = i_stat.use_div ? S_DIV : S_SLEW;
            end
            S_DIV: begin
                o_cmd.div_step = 1'b1;
                n_cnt          = r_cnt + 1'b1;
                if (r_cnt == DIV_CNT_W'(DIV_STEPS - 1)) begin
                    n_state = S_SLEW;
                end
            end
            S_SLEW: begin
                o_cmd.slew = 1'b1;
                n_state    = S_DONE;
            end
            S_DONE: begin
                // wait for the output register to free up
                if (!r_out_valid || m_axis_tready) begin
                    o_cmd.load_out = 1'b1;
                    n_out_valid    = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_cnt       <= n_cnt;
            r_out_valid <= n_out_valid;
        end
    end

    assign s_axis_tready = (r_state == S_IDLE);
    assign m_axis_tvalid = r_out_valid;

endmodule

`default_nettype wire

FILE: hdl/lshs_dpath.sv
// Datapath: config registers, interval accumulator, hysteresis, serial goal divide,
// glow slew and output register. Depends on lshs_pkg; commanded by lshs_ctrl.
`default_nettype none

module lshs_dpath
    import lshs_pkg::*;
(
    input  wire               i_clk,
    input  wire               i_rst_n,
    input  t_dp_cmd           i_cmd,
    output t_dp_stat          o_stat,
    input  wire  [IN_W-1:0]   i_in_data,
    input  wire               i_cfg_we,
    input  wire  [CFG_AW-1:0] i_cfg_addr,
    input  wire  [CFG_DW-1:0] i_cfg_data,
    output logic [OUT_W-1:0]  o_out_data
);

    function automatic logic [LEVEL_W-1:0] max_of(
        input logic [SAMPLE_FIELDS*LEVEL_W-1:0] smp
    );
        logic [LEVEL_W-1:0] best;
        best = '0;
        for (int i = 0; i < NUM_SAMPLES && i < SAMPLE_FIELDS; i++) begin
            if (smp[i*LEVEL_W +: LEVEL_W] > best) begin
                best = smp[i*LEVEL_W +: LEVEL_W];
            end
        end
        return best;
    endfunction

    // configuration
    logic [LEVEL_W-1:0] r_on_limit, r_off_limit;
    logic [CFG_DW-1:0]  r_interval;

    // block state
    logic               r_lit;
    logic [LEVEL_W-1:0] r_level;
    logic [ACCUM_W-1:0] r_accum;
    logic [GLOW_W-1:0]  r_glow;

    // per-beat working registers
    logic [TIME_W-1:0]                r_ts;
    logic [SAMPLE_FIELDS*LEVEL_W-1:0] r_smp;
    logic [EVENT_W-1:0]               r_event;
    logic [LEVEL_W-1:0]               r_num, r_den;
    logic                             r_n_pos, r_n_zero, r_d_zero, r_same_sign;
    logic                             r_direct;
    logic [GLOW_W-1:0]                r_goal;
    logic [GLOW_W-1:0]                r_rem, r_lo, r_quo;
    logic [OUT_W-1:0]                 r_out;

    logic [ACCUM_W:0]   sum_wide;
    logic [ACCUM_W-1:0] accum_sat;
    logic [LEVEL_W-1:0] best;
    logic [LEVEL_W:0]   n_diff, d_diff;
    logic [2*GLOW_W-1:0] dividend;
    logic [GLOW_W:0]    rem_sh;
    logic               q_bit;
    logic [GLOW_W-1:0]  goal;
    logic [GLOW_W:0]    glow_up;
    logic [GLOW_W-1:0]  n_glow;

    assign sum_wide  = {1'b0, r_accum} + (ACCUM_W+1)'(r_ts);
    assign accum_sat = sum_wide[ACCUM_W] ? ACCUM_MAX : sum_wide[ACCUM_W-1:0];
    assign best      = max_of(r_smp);

    assign n_diff = {1'b0, r_level} - {1'b0, r_off_limit};
    assign d_diff = {1'b0, r_on_limit} - {1'b0, r_off_limit};

    // nonzero, same-sign and below the denominator: quotient fits, run the divide
    assign o_stat.use_div = !r_d_zero && !r_n_zero && r_same_sign && (r_num < r_den);

    // num * 65535 = (num << 16) - num
    assign dividend = {r_num, {GLOW_W{1'b0}}} - (2*GLOW_W)'(r_num);

    assign rem_sh = {r_rem, r_lo[GLOW_W-1]};
    assign q_bit  = (rem_sh >= {1'b0, r_den});

    assign goal    = r_direct ? r_goal : r_quo;
    assign glow_up = {1'b0, r_glow} + (GLOW_W+1)'(r_ts);

    always_comb begin
        n_glow = r_glow;
        if (r_glow < goal) begin
            n_glow = (glow_up > {1'b0, goal}) ? goal : glow_up[GLOW_W-1:0];
        end else if (r_glow > goal) begin
            n_glow = ((r_glow - goal) > r_ts) ? (r_glow - r_ts) : goal;
        end
    end

    // state with defined reset values
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_on_limit  <= '0;
            r_off_limit <= '0;
            r_interval  <= INTERVAL_RESET;
            r_lit       <= 1'b0;
            r_level     <= '0;
            r_accum     <= '0;
            r_glow      <= '0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_addr)
                    REG_ON_LIMIT:  r_on_limit  <= i_cfg_data;
                    REG_OFF_LIMIT: r_off_limit <= i_cfg_data;
                    REG_INTERVAL:  r_interval  <= i_cfg_data;
                    default: begin
                    end
                endcase
            end
            if (i_cmd.eval) begin
                if (accum_sat >= {1'b0, r_interval}) begin
                    r_accum <= '0;
                    r_level <= best;
                    if (r_lit) begin
                        if (best < r_off_limit) begin
                            r_lit <= 1'b0;
                        end
                    end else if (best > r_on_limit) begin
                        r_lit <= 1'b1;
                    end
                end else begin
                    r_accum <= accum_sat;
                end
            end
            if (i_cmd.slew) begin
                r_glow <= n_glow;
            end
        end
    end

    // working registers, no reset needed
    always_ff @(posedge i_clk) begin
        if (i_cmd.cap_in) begin
            r_ts  <= i_in_data[TIME_W-1:0];
            r_smp <= i_in_data[IN_W-1:TIME_W];
        end
        if (i_cmd.eval) begin
            r_event <= EV_NONE;
            if (accum_sat >= {1'b0, r_interval}) begin
                if (r_lit && (best < r_off_limit)) begin
                    r_event <= EV_OFF;
                end else if (!r_lit && (best > r_on_limit)) begin
                    r_event <= EV_ON;
                end
            end
        end
        if (i_cmd.prep) begin
            r_num       <= n_diff[LEVEL_W] ? LEVEL_W'(-n_diff) : n_diff[LEVEL_W-1:0];
            r_den       <= d_diff[LEVEL_W] ? LEVEL_W'(-d_diff) : d_diff[LEVEL_W-1:0];
            r_n_pos     <= !n_diff[LEVEL_W] && (n_diff != '0);
            r_n_zero    <= (n_diff == '0);
            r_d_zero    <= (d_diff == '0);
            r_same_sign <= (n_diff[LEVEL_W] == d_diff[LEVEL_W]);
        end
        if (i_cmd.load) begin
            r_direct <= !o_stat.use_div;
            r_rem    <= dividend[2*GLOW_W-1:GLOW_W];
            r_lo     <= dividend[GLOW_W-1:0];
            r_quo    <= '0;
            if (r_d_zero) begin
                // equal limits: step at the off limit
                r_goal <= r_n_pos ? FULL_GLOW : '0;
            end else if (r_n_zero || !r_same_sign) begin
                r_goal <= '0;
            end else begin
                r_goal <= FULL_GLOW;
            end
        end
        if (i_cmd.div_step) begin
            r_rem <= q_bit ? GLOW_W'(rem_sh - {1'b0, r_den}) : rem_sh[GLOW_W-1:0];
            r_lo  <= {r_lo[GLOW_W-2:0], 1'b0};
            r_quo <= {r_quo[GLOW_W-2:0], q_bit};
        end
        if (i_cmd.load_out) begin
            r_out <= OUT_W'({r_glow, r_level, r_event, r_lit});
        end
    end

    assign o_out_data = r_out;

endmodule

`default_nettype wire

FILE: test/light_sensor_hysteresis_slew_test.sv
// Self-checking bench for light_sensor_hysteresis_slew: directed and random ticks,
// with an in-bench predictor of the hysteresis, level hold and glow slew.
// Depends on lshs_pkg and the block's RTL only.

module light_sensor_hysteresis_slew_test
    import lshs_pkg::*;
();

    localparam int CYCLE_LIMIT = 1_000_000;
    localparam int SETTLE_CYCLES = 40;

    // one input beat; the time step sits in the low bits as on the bus
    typedef struct packed {
        logic [SAMPLE_FIELDS-1:0][LEVEL_W-1:0] smp;
        logic [TIME_W-1:0]                     dt;
    } t_tick;

    typedef struct packed {
        logic [GLOW_W-1:0]  glow;
        logic [LEVEL_W-1:0] held;
        logic [EVENT_W-1:0] ev;
        logic               lit;
    } t_light_result;

    logic              clk = 1'b0;
    logic              rst_n = 1'b0;
    logic              s_tvalid = 1'b0;
    logic              s_tready;
    logic [IN_W-1:0]   s_tdata = '0;
    logic              m_tvalid;
    logic              m_tready = 1'b0;
    logic [OUT_W-1:0]  m_tdata;
    logic              cfg_we = 1'b0;
    logic [CFG_AW-1:0] cfg_addr = '0;
    logic [CFG_DW-1:0] cfg_data = '0;

    // predictor copy of registers and state
    logic [LEVEL_W-1:0] on_lim = '0;
    logic [LEVEL_W-1:0] off_lim = '0;
    logic [CFG_DW-1:0]  intv_reg = INTERVAL_RESET;
    logic               lit_now = 1'b0;
    logic [LEVEL_W-1:0] held_now = '0;
    logic [ACCUM_W-1:0] accum_now = '0;
    logic [GLOW_W-1:0]  glow_now = '0;

    t_tick         pending_ticks[$];
    t_light_result expected_results[$];
    t_tick         offered;

    int   send_idle_pct = 0;
    int   recv_stall_pct = 0;
    int   mismatches = 0;
    int   cycle_count = 0;
    int   hold_cycles = 0;
    logic hold_request = 1'b0;

    light_sensor_hysteresis_slew DUT (
        .i_clk         (clk),
        .i_rst_n       (rst_n),
        .s_axis_tvalid (s_tvalid),
        .s_axis_tready (s_tready),
        .s_axis_tdata  (s_tdata),
        .m_axis_tvalid (m_tvalid),
        .m_axis_tready (m_tready),
        .m_axis_tdata  (m_tdata),
        .i_cfg_we      (cfg_we),
        .i_cfg_addr    (cfg_addr),
        .i_cfg_data    (cfg_data)
    );

    always #5 clk = ~clk;

    // (level - off) / (on - off) as Q0.16, clamped to 0..1; step when limits are equal
    function automatic logic [GLOW_W-1:0] glow_target(input logic [LEVEL_W-1:0] lvl);
        longint num, den, q;
        num = longint'(lvl) - longint'(off_lim);
        den = longint'(on_lim) - longint'(off_lim);
        if (den == 0) return (num > 0) ? FULL_GLOW : '0;
        if (num == 0 || ((num < 0) != (den < 0))) return '0;
        if (num < 0) num = -num;
        if (den < 0) den = -den;
        q = num * longint'(FULL_GLOW) / den;
        return (q > longint'(FULL_GLOW)) ? FULL_GLOW : q[GLOW_W-1:0];
    endfunction

    function automatic t_light_result advance_sensor(input t_tick t);
        logic [ACCUM_W:0]   sum;
        logic [LEVEL_W-1:0] peak;
        logic [GLOW_W-1:0]  target;
        logic [GLOW_W:0]    raised;
        t_light_result      r;
        r.ev = EV_NONE;
        sum = accum_now + t.dt;
        if (sum > ACCUM_MAX) sum = ACCUM_MAX;
        accum_now = sum[ACCUM_W-1:0];
        if (accum_now >= intv_reg) begin
            accum_now = '0;
            peak = '0;
            for (int i = 0; i < NUM_SAMPLES; i++)
                if (t.smp[i] > peak) peak = t.smp[i];
            held_now = peak;
            if (lit_now) begin
                if (held_now < off_lim) begin
                    lit_now = 1'b0;
                    r.ev = EV_OFF;
                end
            end else if (held_now > on_lim) begin
                lit_now = 1'b1;
                r.ev = EV_ON;
            end
        end
        target = glow_target(held_now);
        if (glow_now < target) begin
            raised = glow_now + t.dt;
            glow_now = (raised > target) ? target : raised[GLOW_W-1:0];
        end else if (glow_now > target) begin
            glow_now = (glow_now - target > t.dt) ? glow_now - t.dt : target;
        end
        r.lit = lit_now;
        r.held = held_now;
        r.glow = glow_now;
        return r;
    endfunction

    // sender: offers queued ticks, predicts on each accepted beat
    always @(posedge clk) begin
        if (!rst_n) begin
            s_tvalid <= 1'b0;
        end else begin
            if (s_tvalid && s_tready)
                expected_results.push_back(advance_sensor(offered));
            if (!s_tvalid || s_tready) begin
                if (pending_ticks.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                    offered = pending_ticks.pop_front();
                    s_tdata <= offered;
                    s_tvalid <= 1'b1;
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // receiver: checks each accepted result beat against the oldest prediction
    always @(posedge clk) begin : watch
        t_light_result got, want;
        if (!rst_n) begin
            m_tready <= 1'b0;
        end else begin
            if (m_tvalid && m_tready) begin
                got = m_tdata[$bits(t_light_result)-1:0];
                if (expected_results.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected result beat: lit=%0d ev=%0d level=%h glow=%h",
                                 got.lit, got.ev, got.held, got.glow);
                end else begin
                    want = expected_results.pop_front();
                    if (got.lit !== want.lit || got.ev !== want.ev ||
                        got.held !== want.held || got.glow !== want.glow) begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display({"mismatch: exp lit=%0d ev=%0d level=%h glow=%h,",
                                      " got lit=%0d ev=%0d level=%h glow=%h"},
                                     want.lit, want.ev, want.held, want.glow,
                                     got.lit, got.ev, got.held, got.glow);
                    end
                end
            end
            m_tready <= (hold_cycles == 0) && ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // long receiver hold-off, counted here
    always @(posedge clk) begin
        if (!rst_n)
            hold_cycles <= 0;
        else if (hold_request && hold_cycles == 0)
            hold_cycles <= 500;
        else if (hold_cycles != 0)
            hold_cycles <= hold_cycles - 1;
    end

    always @(posedge clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("tb: failure");
            $finish;
        end
    end

    function automatic void add_tick(input logic [TIME_W-1:0] ts,
                                     input logic [LEVEL_W-1:0] peak, input int where);
        t_tick t;
        t.dt = ts;
        for (int i = 0; i < SAMPLE_FIELDS; i++)
            t.smp[i] = (i == where) ? peak : peak >> 1;
        pending_ticks.push_back(t);
    endfunction

    // levels cluster around the limits so the hysteresis toggles often
    function automatic t_tick random_tick();
        t_tick t;
        int    peak;
        case ($urandom_range(9))
            0:       t.dt = '0;
            1:       t.dt = '1;
            2, 3, 4: t.dt = TIME_W'($urandom_range(intv_reg));
            5:       t.dt = TIME_W'($urandom_range(63));
            default: t.dt = TIME_W'($urandom_range(16'hFFFF));
        endcase
        case ($urandom_range(5))
            0:       peak = int'(on_lim) + int'($urandom_range(64)) - 32;
            1:       peak = int'(off_lim) + int'($urandom_range(64)) - 32;
            2:       peak = 0;
            3:       peak = 16'hFFFF;
            default: peak = $urandom_range(16'hFFFF);
        endcase
        if (peak < 0) peak = 0;
        if (peak > 16'hFFFF) peak = 16'hFFFF;
        if ($urandom_range(4) == 0) begin
            for (int i = 0; i < SAMPLE_FIELDS; i++)
                t.smp[i] = LEVEL_W'($urandom_range(16'hFFFF));
        end else begin
            for (int i = 0; i < SAMPLE_FIELDS; i++)
                t.smp[i] = LEVEL_W'($urandom_range(peak));
            t.smp[$urandom_range(SAMPLE_FIELDS - 1)] = LEVEL_W'(peak);
        end
        return t;
    endfunction

    task automatic settle();
        while (pending_ticks.size() != 0 || s_tvalid || expected_results.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_AW-1:0] idx, input logic [CFG_DW-1:0] val);
        @(posedge clk);
        cfg_we <= 1'b1;
        cfg_addr <= idx;
        cfg_data <= val;
        case (idx)
            REG_ON_LIMIT:  on_lim = val;
            REG_OFF_LIMIT: off_lim = val;
            REG_INTERVAL:  intv_reg = val;
            default: ;
        endcase
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic run_phase(input logic [CFG_DW-1:0] on_v, input logic [CFG_DW-1:0] off_v,
                             input logic [CFG_DW-1:0] intv_v, input int idle, input int stall,
                             input int count);
        settle();
        write_reg(REG_ON_LIMIT, on_v);
        write_reg(REG_OFF_LIMIT, off_v);
        write_reg(REG_INTERVAL, intv_v);
        send_idle_pct = idle;
        recv_stall_pct = stall;
        repeat (count) pending_ticks.push_back(random_tick());
    endtask

    initial begin
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        // reset settings: equal limits at zero, default interval
        add_tick(16'h0000, 16'h0000, 0);
        add_tick(16'hFFFF, 16'hFFFF, 5);
        add_tick(16'h0800, 16'h0000, 2);
        add_tick(16'h0100, 16'h0000, 3);

        // normal band: turn on, levels on both limits, turn off
        run_phase(16'h3000, 16'h1000, 16'h1000, 0, 0, 0);
        add_tick(16'h0800, 16'h3001, 1);
        add_tick(16'h0800, 16'h3001, 4);
        add_tick(16'h1000, 16'h3000, 0);
        add_tick(16'h1000, 16'h1000, 5);
        add_tick(16'h1000, 16'h0FFF, 2);
        add_tick(16'h1000, 16'h3000, 3);
        add_tick(16'h1000, 16'h2000, 1);

        // inverted limits, evaluating on every tick
        run_phase(16'h1000, 16'h3000, 16'h0000, 0, 0, 0);
        add_tick(16'h0000, 16'h0800, 0);
        add_tick(16'h0400, 16'h2000, 2);
        add_tick(16'hFFFF, 16'h3800, 4);
        add_tick(16'h0001, 16'h0000, 5);

        // equal limits: goal is a step at the off limit
        run_phase(16'h8000, 16'h8000, 16'h0001, 0, 0, 0);
        add_tick(16'h0000, 16'h8001, 0);
        add_tick(16'h0001, 16'h8001, 3);
        add_tick(16'h7FFF, 16'h8000, 5);
        add_tick(16'h0010, 16'h7FFF, 1);

        // widest band and longest interval
        run_phase(16'hFFFF, 16'h0000, 16'hFFFF, 0, 0, 0);
        add_tick(16'hFFFF, 16'hFFFF, 0);
        add_tick(16'hFFFE, 16'h0000, 2);
        add_tick(16'hFFFF, 16'hFFFF, 4);

        run_phase(16'h0000, 16'hFFFF, 16'h0000, 0, 0, 0);
        add_tick(16'h0000, 16'h0001, 0);
        add_tick(16'hFFFF, 16'hFFFE, 3);

        // random part, cycling through the idling patterns
        run_phase(16'h3000, 16'h1000, 16'h0888, 0, 0, 250);
        run_phase(16'hFFFF, 16'h0000, 16'hFFFF, 75, 0, 250);
        run_phase(16'h0000, 16'hFFFF, 16'h0001, 0, 75, 250);
        run_phase(16'h2000, 16'h2000, 16'h0000, 23, 23, 250);
        run_phase(CFG_DW'($urandom_range(16'hFFFF)), CFG_DW'($urandom_range(16'hFFFF)),
                  CFG_DW'($urandom_range(1, 16'hFFFF)), 0, 0, 250);

        // receiver holds off while the sender keeps offering: input must stall
        run_phase(16'h4000, 16'h2000, 16'h0100, 0, 0, 60);
        @(posedge clk);
        hold_request <= 1'b1;
        @(posedge clk);
        hold_request <= 1'b0;

        run_phase(16'h1000, 16'h4000, 16'h0400, 75, 0, 250);
        run_phase(CFG_DW'($urandom_range(16'hFFFF)), CFG_DW'($urandom_range(16'hFFFF)),
                  CFG_DW'($urandom_range(16'hFFFF)), 0, 75, 250);
        run_phase(16'h8000, 16'h7FFF, 16'h2000, 23, 23, 250);
        settle();

        mismatches += expected_results.size();
        if (mismatches == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
